[hdl/fmma_pkg.sv]
// types, constants and single-precision arithmetic helpers for the matrix multiply-accumulate
`default_nettype none
package fmma_pkg;

  // command codes of the mode field
  localparam logic [2:0] MODE_LOAD_A  = 3'd0;
  localparam logic [2:0] MODE_LOAD_B  = 3'd1;
  localparam logic [2:0] MODE_LOAD_C  = 3'd2;
  localparam logic [2:0] MODE_COMPUTE = 3'd3;
  localparam logic [2:0] MODE_READ_C  = 3'd4;

  // result kinds
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;

  // index field width and the number of values it spans
  localparam int IDX_W    = 6;
  localparam int IDX_SPAN = 1 << IDX_W;

  // cycles between two depth steps handed to one cell
  localparam int STEP_CYCLES = 6;

  localparam logic [31:0] QNAN_BIT = 32'h0040_0000;
  localparam logic [31:0] DEF_NAN  = 32'hFFC0_0000;

  // one depth step travelling down the row of cells
  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic [31:0] a;
    logic [7:0]  row;
    logic [7:0]  q;
    logic [7:0]  blk;
    logic [8:0]  jbase;
  } token_t;

  // host access to the stores held in a cell
  typedef struct packed {
    logic        we_b;
    logic        we_c;
    logic        rd_c;
    logic [7:0]  row;
    logic [7:0]  blk;
    logic [31:0] data;
  } host_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [9:0]  e;
    logic [47:0]        p;
  } mul_raw_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [9:0]  e;
    logic [27:0]        r;
  } add_raw_t;

  // normalized value: 24 significant bits, guard, sticky
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [9:0]  e;
    logic [25:0]        m;
  } norm_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd0;
    found = 1'b0;
    for (int k = 47; k >= 0; k--) begin
      if (!found) begin
        if (v[k]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic mul_raw_t fp_mul(input logic [31:0] a, input logic [31:0] b);
    mul_raw_t          r;
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic signed [9:0] ea_e, eb_e;
    logic [23:0]       ma, mb;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea_e = (a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, a[30:23]});
    eb_e = (b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b[30:23]});
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    r.sign = a[31] ^ b[31];
    r.p = ma * mb;
    r.e = ea_e + eb_e - 10'sd126;
    r.spec = 1'b1;
    if (a_nan) r.spec_bits = a | QNAN_BIT;
    else if (b_nan) r.spec_bits = b | QNAN_BIT;
    else if ((a_inf && b_zero) || (a_zero && b_inf)) r.spec_bits = DEF_NAN;
    else if (a_inf || b_inf) r.spec_bits = {r.sign, 8'hFF, 23'd0};
    else begin
      r.spec = 1'b0;
      r.spec_bits = 32'd0;
    end
    return r;
  endfunction

  function automatic norm_t mul_norm(input mul_raw_t x);
    norm_t       r;
    logic [5:0]  lz;
    logic [47:0] pn;
    lz = lzc48(x.p);
    pn = x.p << lz;
    r.spec = x.spec;
    r.spec_bits = x.spec_bits;
    r.sign = x.sign;
    r.e = x.e - $signed({4'b0000, lz});
    r.m = {pn[47:23], |pn[22:0]};
    return r;
  endfunction

  function automatic add_raw_t fp_add_align(input logic [31:0] x, input logic [31:0] y);
    add_raw_t    r;
    logic        x_nan, y_nan, x_inf, y_inf, swap;
    logic [31:0] big, sml;
    logic [7:0]  eb8, es8, d;
    logic [27:0] big_w, sml_w, sh_w;
    x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
    x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
    swap = (y[30:0] > x[30:0]);
    big = swap ? y : x;
    sml = swap ? x : y;
    eb8 = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es8 = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d = eb8 - es8;
    big_w = {1'b0, (big[30:23] != 8'd0), big[22:0], 3'b000};
    sml_w = {1'b0, (sml[30:23] != 8'd0), sml[22:0], 3'b000};
    if (d >= 8'd27) sh_w = {27'd0, |sml_w};
    else sh_w = (sml_w >> d) | {27'd0, |(sml_w & ((28'd1 << d) - 28'd1))};
    r.r = (x[31] ^ y[31]) ? (big_w - sh_w) : (big_w + sh_w);
    r.sign = (r.r == 28'd0) ? (x[31] & y[31]) : big[31];
    r.e = $signed({2'b00, eb8});
    r.spec = 1'b1;
    if (x_nan) r.spec_bits = x | QNAN_BIT;
    else if (y_nan) r.spec_bits = y | QNAN_BIT;
    else if (x_inf && y_inf && (x[31] != y[31])) r.spec_bits = DEF_NAN;
    else if (x_inf) r.spec_bits = x;
    else if (y_inf) r.spec_bits = y;
    else begin
      r.spec = 1'b0;
      r.spec_bits = 32'd0;
    end
    return r;
  endfunction

  function automatic norm_t add_norm(input add_raw_t z);
    norm_t       r;
    logic [5:0]  lz;
    logic [27:0] rn;
    lz = lzc48({z.r, 20'd0});
    rn = z.r << lz;
    r.spec = z.spec;
    r.spec_bits = z.spec_bits;
    r.sign = z.sign;
    r.e = z.e + 10'sd1 - $signed({4'b0000, lz});
    r.m = {rn[27:3], |rn[2:0]};
    return r;
  endfunction

  // round to nearest even and pack, subnormals and overflow included
  function automatic logic [31:0] fp_round(input norm_t x);
    logic signed [9:0] e;
    logic [25:0]       m;
    logic [9:0]        sh;
    logic [24:0]       sig;
    logic              inc;
    logic [7:0]        ef;
    logic [22:0]       frac;
    e = x.e;
    m = x.m;
    if (x.spec) return x.spec_bits;
    if (m == 26'd0) return {x.sign, 31'd0};
    if (e <= 10'sd0) begin
      sh = 10'sd1 - e;
      if (sh > 10'd25) m = {25'd0, |m};
      else m = (m >> sh) | {25'd0, |(m & ((26'd1 << sh) - 26'd1))};
      e = 10'sd0;
    end
    inc = m[1] & (m[0] | m[2]);
    sig = {1'b0, m[25:2]} + {24'd0, inc};
    if (e == 10'sd0) begin
      ef = {7'd0, sig[23]};
      frac = sig[22:0];
    end else begin
      if (sig[24]) begin
        e = e + 10'sd1;
        frac = sig[23:1];
      end else begin
        frac = sig[22:0];
      end
      if (e >= 10'sd255) return {x.sign, 8'hFF, 23'd0};
      ef = e[7:0];
    end
    return {x.sign, ef, frac};
  endfunction

endpackage
`default_nettype wire

[hdl/float_matrix_multiply_accumulate.sv]
// top level: command decode, size registers, A store, pass sequencer and the row of cells
`default_nettype none
// usage
//   command channel: an item transfers at a rising edge with start_i high and busy_o low;
//   mode_i selects load A, load B, load C, compute or read C, addressed by row/column
//   result channel: result_valid_o marks one cycle; the receiver cannot stall it
//   configuration: cfg_we_i writes cfg_data_i into register cfg_index_i (rows, cols,
//   depth), values above the parameter maximum saturate; write only while idle
// loads, reads and compute
//   loads and reads can follow back to back; read data and index errors show in
//   the cycle after the transfer
//   compute holds busy_o until the last depth step has drained; each cell runs
//   its depth steps through its multiply / round / add / round pipeline
//   the done result shows on the cycle busy_o falls; an empty size gives it
//   without a pass, and busy_o stays low
// reset
//   sizes return to 64, or to the parameter maximum where smaller, the sequencer idles, the element
//   stores keep whatever they held and must be loaded before use
module float_matrix_multiply_accumulate #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_DEPTH = 64,
  parameter int TILE_SIZE = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  mode_i,
  input  logic [5:0]  row_index_i,
  input  logic [5:0]  col_index_i,
  input  logic [31:0] element_bits_i,
  output logic        result_valid_o,
  output logic        result_kind_o,
  output logic [31:0] result_bits_o,
  output logic        index_error_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);
  import fmma_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW    = (TILE_SIZE > 1) ? $clog2(TILE_SIZE) : 1;
  localparam int PHW   = $clog2(STEP_CYCLES);
  localparam int DRAIN = TILE_SIZE + 4;
  localparam int DRW   = $clog2(DRAIN + 1);
  localparam logic [8:0] ROWS_RST  = (64 > MAX_ROWS) ? 9'(MAX_ROWS) : 9'd64;
  localparam logic [8:0] COLS_RST  = (64 > MAX_COLS) ? 9'(MAX_COLS) : 9'd64;
  localparam logic [8:0] DEPTH_RST = (64 > MAX_DEPTH) ? 9'(MAX_DEPTH) : 9'd64;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  function automatic logic [8:0] clamp_size(input logic [6:0] v, input int maxv);
    return ({2'b00, v} > 9'(maxv)) ? 9'(maxv) : {2'b00, v};
  endfunction

  logic [1:0]     state_q;
  logic [8:0]     rows_q, cols_q, depth_q;
  logic [7:0]     i_q, q_q, blk_q;
  logic [8:0]     jb_q;
  logic [PHW-1:0] ph_q;
  logic [DRW-1:0] drn_q;
  logic           out_vld_q, out_kind_q, out_err_q, out_mem_q;
  logic [LW-1:0]  out_lane_q;
  logic [31:0]    a_rd_q;
  logic [31:0]    a_mem [0:(1 << (RW + DW)) - 1];

  logic           accept, in_range, size_zero;
  logic [8:0]     row_lim, col_lim;
  logic           q_last, blk_last, row_last;
  logic [LW-1:0]  lane_tab [IDX_SPAN];
  logic [7:0]     blk_tab  [IDX_SPAN];
  host_t          host_all;
  host_t          host_c   [TILE_SIZE];
  token_t         tok      [TILE_SIZE + 1];
  logic [31:0]    c_rd     [TILE_SIZE];

  // column to lane and column block, worked out at elaboration
  for (genvar v = 0; v < IDX_SPAN; v++) begin : g_tab
    assign lane_tab[v] = LW'(v % TILE_SIZE);
    assign blk_tab[v]  = 8'(v / TILE_SIZE);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // bounds follow the store that the mode addresses
  always_comb begin
    unique case (mode_i)
      MODE_LOAD_A: begin
        row_lim = rows_q;
        col_lim = depth_q;
      end
      MODE_LOAD_B: begin
        row_lim = depth_q;
        col_lim = cols_q;
      end
      default: begin
        row_lim = rows_q;
        col_lim = cols_q;
      end
    endcase
  end
  assign in_range = ({3'b000, row_index_i} < row_lim) && ({3'b000, col_index_i} < col_lim);
  assign size_zero = (rows_q == 9'd0) || (cols_q == 9'd0) || (depth_q == 9'd0);

  // host side of the lane stores, steered to one cell below
  always_comb begin
    host_all.we_b = accept && (mode_i == MODE_LOAD_B) && in_range;
    host_all.we_c = accept && (mode_i == MODE_LOAD_C) && in_range;
    host_all.rd_c = accept && (mode_i == MODE_READ_C) && in_range;
    host_all.row  = 8'(row_index_i);
    host_all.blk  = blk_tab[col_index_i];
    host_all.data = element_bits_i;
  end

  // sequencer loop ends
  assign q_last   = ({1'b0, q_q} == (depth_q - 9'd1));
  assign blk_last = (({1'b0, jb_q} + 10'(TILE_SIZE)) >= {1'b0, cols_q});
  assign row_last = ({1'b0, i_q} == (rows_q - 9'd1));

  // one depth step enters the chain on phase one, with A read on phase zero
  always_comb begin
    tok[0].valid = (state_q == ST_RUN) && (ph_q == PHW'(1));
    tok[0].first = (q_q == 8'd0);
    tok[0].last  = q_last;
    tok[0].a     = a_rd_q;
    tok[0].row   = i_q;
    tok[0].q     = q_q;
    tok[0].blk   = blk_q;
    tok[0].jbase = jb_q;
  end

  always_ff @(posedge clk_i) begin
    if (accept && (mode_i == MODE_LOAD_A) && in_range) begin
      a_mem[{RW'(row_index_i), DW'(col_index_i)}] <= element_bits_i;
    end
    if ((state_q == ST_RUN) && (ph_q == PHW'(0))) begin
      a_rd_q <= a_mem[{i_q[RW-1:0], q_q[DW-1:0]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rows_q     <= ROWS_RST;
      cols_q     <= COLS_RST;
      depth_q    <= DEPTH_RST;
      i_q        <= '0;
      q_q        <= '0;
      blk_q      <= '0;
      jb_q       <= '0;
      ph_q       <= '0;
      drn_q      <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= KIND_DONE;
      out_err_q  <= 1'b0;
      out_mem_q  <= 1'b0;
      out_lane_q <= '0;
    end else begin
      out_vld_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_ROWS) rows_q <= clamp_size(cfg_data_i, MAX_ROWS);
        if (cfg_index_i == REG_COLS) cols_q <= clamp_size(cfg_data_i, MAX_COLS);
        if (cfg_index_i == REG_DEPTH) depth_q <= clamp_size(cfg_data_i, MAX_DEPTH);
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (mode_i)
              MODE_LOAD_A, MODE_LOAD_B, MODE_LOAD_C: begin
                // in-range loads answer nothing, bad indexes answer a flagged zero
                if (!in_range) begin
                  out_vld_q  <= 1'b1;
                  out_kind_q <= KIND_READ;
                  out_err_q  <= 1'b1;
                  out_mem_q  <= 1'b0;
                end
              end
              MODE_READ_C: begin
                out_vld_q  <= 1'b1;
                out_kind_q <= KIND_READ;
                out_err_q  <= !in_range;
                out_mem_q  <= in_range;
                out_lane_q <= lane_tab[col_index_i];
              end
              MODE_COMPUTE: begin
                if (size_zero) begin
                  out_vld_q  <= 1'b1;
                  out_kind_q <= KIND_DONE;
                  out_err_q  <= 1'b0;
                  out_mem_q  <= 1'b0;
                end else begin
                  state_q <= ST_RUN;
                  i_q     <= '0;
                  q_q     <= '0;
                  blk_q   <= '0;
                  jb_q    <= '0;
                  ph_q    <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (ph_q == PHW'(STEP_CYCLES - 1)) begin
            ph_q <= '0;
            if (!q_last) begin
              q_q <= q_q + 8'd1;
            end else begin
              q_q <= '0;
              if (!blk_last) begin
                jb_q  <= jb_q + 9'(TILE_SIZE);
                blk_q <= blk_q + 8'd1;
              end else begin
                jb_q  <= '0;
                blk_q <= '0;
                if (row_last) begin
                  state_q <= ST_DRAIN;
                  drn_q   <= DRW'(DRAIN - 1);
                end else begin
                  i_q <= i_q + 8'd1;
                end
              end
            end
          end else begin
            ph_q <= ph_q + PHW'(1);
          end
        end
        ST_DRAIN: begin
          // let the last step clear every cell and reach its C store
          if (drn_q == '0) begin
            state_q    <= ST_IDLE;
            out_vld_q  <= 1'b1;
            out_kind_q <= KIND_DONE;
            out_err_q  <= 1'b0;
            out_mem_q  <= 1'b0;
          end else begin
            drn_q <= drn_q - DRW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the row of cells, lane t owns columns t, t + TILE_SIZE, ...
  for (genvar t = 0; t < TILE_SIZE; t++) begin : g_cell
    always_comb begin
      host_c[t]      = host_all;
      host_c[t].we_b = host_all.we_b && (lane_tab[col_index_i] == LW'(t));
      host_c[t].we_c = host_all.we_c && (lane_tab[col_index_i] == LW'(t));
      host_c[t].rd_c = host_all.rd_c && (lane_tab[col_index_i] == LW'(t));
    end
    fmma_cell #(
      .LANE      (t),
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_DEPTH (MAX_DEPTH),
      .TILE_SIZE (TILE_SIZE)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cols_i (cols_q),
      .tok_i  (tok[t]),
      .tok_o  (tok[t+1]),
      .host_i (host_c[t]),
      .c_rd_o (c_rd[t])
    );
  end

  assign result_valid_o = out_vld_q;
  assign result_kind_o  = out_kind_q;
  assign index_error_o  = out_err_q;
  assign result_bits_o  = (out_vld_q && out_mem_q) ? c_rd[out_lane_q] : 32'd0;

`ifndef SYNTHESIS
  // a pass ends only when the sequencer goes idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_kind_o == KIND_DONE)) |-> !busy_o)
    else $error("compute done shown while busy");
  // read and error answers come from transfers taken while idle
  a_read_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_kind_o == KIND_READ)) |-> !$past(busy_o))
    else $error("read answer without an idle transfer");
  // busy starts only on a compute transfer
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (mode_i == MODE_COMPUTE)))
    else $error("busy without compute command");
  // no step leaves the end of the chain once the pass is over
  a_chain_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[TILE_SIZE].valid |-> busy_o)
    else $error("step left the chain after the pass");
`endif

endmodule
`default_nettype wire

[hdl/fmma_cell.sv]
// one multiply-accumulate cell: owns a column lane of B and C and passes steps on
`default_nettype none
module fmma_cell #(
  parameter int LANE      = 0,
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int MAX_DEPTH = 64,
  parameter int TILE_SIZE = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [8:0]       cols_i,
  input  fmma_pkg::token_t tok_i,
  output fmma_pkg::token_t tok_o,
  input  fmma_pkg::host_t  host_i,
  output logic [31:0]      c_rd_o
);
  import fmma_pkg::*;

  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DW   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int NBLK = (MAX_COLS + TILE_SIZE - 1) / TILE_SIZE;
  localparam int BW   = (NBLK > 1) ? $clog2(NBLK) : 1;

  logic [31:0] b_mem [0:(1 << (DW + BW)) - 1];
  logic [31:0] c_mem [0:(1 << (RW + BW)) - 1];

  token_t      tok_q;
  logic        act;
  logic [31:0] b_rd_q, c_rd_q;
  logic [5:0]  vld_q;
  logic        first_q, last_q;
  logic [31:0] a_q, acc_q, accop_q, prod_q, res;
  logic [RW+BW-1:0] caddr_q, c_raddr;
  mul_raw_t    m1_q;
  norm_t       n2_q, n5_q;
  add_raw_t    r4_q;

  assign act = tok_q.valid &&
               (({1'b0, tok_q.jbase} + 10'(LANE)) < {1'b0, cols_i});
  assign c_raddr = act ? {tok_q.row[RW-1:0], tok_q.blk[BW-1:0]}
                       : {host_i.row[RW-1:0], host_i.blk[BW-1:0]};
  assign res = fp_round(n5_q);
  assign tok_o = tok_q;
  assign c_rd_o = c_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      vld_q <= '0;
    end else begin
      tok_q <= tok_i;
      vld_q <= {vld_q[4:0], act};
    end
  end

  // stores of this lane
  always_ff @(posedge clk_i) begin
    if (host_i.we_b) b_mem[{host_i.row[DW-1:0], host_i.blk[BW-1:0]}] <= host_i.data;
    if (act) b_rd_q <= b_mem[{tok_q.q[DW-1:0], tok_q.blk[BW-1:0]}];
    if (host_i.we_c) c_mem[{host_i.row[RW-1:0], host_i.blk[BW-1:0]}] <= host_i.data;
    else if (vld_q[5] && last_q) c_mem[caddr_q] <= res;
    if ((act && tok_q.first) || host_i.rd_c) c_rd_q <= c_mem[c_raddr];
  end

  // multiply, round, add, round
  always_ff @(posedge clk_i) begin
    if (act) begin
      a_q     <= tok_q.a;
      first_q <= tok_q.first;
      last_q  <= tok_q.last;
      caddr_q <= {tok_q.row[RW-1:0], tok_q.blk[BW-1:0]};
    end
    if (vld_q[0]) begin
      m1_q    <= fp_mul(a_q, b_rd_q);
      accop_q <= first_q ? c_rd_q : acc_q;
    end
    if (vld_q[1]) n2_q <= mul_norm(m1_q);
    if (vld_q[2]) prod_q <= fp_round(n2_q);
    if (vld_q[3]) r4_q <= fp_add_align(accop_q, prod_q);
    if (vld_q[4]) n5_q <= add_norm(r4_q);
    if (vld_q[5]) acc_q <= res;
  end

endmodule
`default_nettype wire
